// ===== sv/cc20_pkg.sv =====
// Package for the ChaCha20 stream XOR block: constants, sequencer states,
// and the quarter-round operand struct. No dependencies.
package cc20_pkg;

  localparam int DoubleRoundsDefault = 10;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegKey0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSalt = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInitCount = 3'd5;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  // Quarter-round column/diagonal index for step q (0..7).
  function automatic logic [15:0] qr_index(input logic [2:0] q);
    logic [15:0] r;
    case (q)
      3'd0: r = {4'd0, 4'd4, 4'd8, 4'd12};
      3'd1: r = {4'd1, 4'd5, 4'd9, 4'd13};
      3'd2: r = {4'd2, 4'd6, 4'd10, 4'd14};
      3'd3: r = {4'd3, 4'd7, 4'd11, 4'd15};
      3'd4: r = {4'd0, 4'd5, 4'd10, 4'd15};
      3'd5: r = {4'd1, 4'd6, 4'd11, 4'd12};
      3'd6: r = {4'd2, 4'd7, 4'd8, 4'd13};
      default: r = {4'd3, 4'd4, 4'd9, 4'd14};
    endcase
    return r;
  endfunction

endpackage

// ===== sv/cc20_stream_if.sv =====
// Valid/ready stream interface carrying a generic payload.
// Depends on nothing.
interface cc20_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== sv/cc20_quarter.sv =====
// ChaCha quarter-round: the shared arithmetic unit, one quarter-round a call.
// Depends on cc20_pkg.
module cc20_quarter (
  input  cc20_pkg::quad_t in_q,
  output cc20_pkg::quad_t out_q
);
  logic [31:0] a1, d1, c1, b1, a2, d2, c2, b2;
  logic [31:0] t0, t1, t2, t3;

  always_comb begin
    a1 = in_q.a + in_q.b;
    t0 = in_q.d ^ a1;
    d1 = {t0[15:0], t0[31:16]};
    c1 = in_q.c + d1;
    t1 = in_q.b ^ c1;
    b1 = {t1[19:0], t1[31:20]};
    a2 = a1 + b1;
    t2 = d1 ^ a2;
    d2 = {t2[23:0], t2[31:24]};
    c2 = c1 + d2;
    t3 = b1 ^ c2;
    b2 = {t3[24:0], t3[31:25]};
    out_q = '{a: a2, b: b2, c: c2, d: d2};
  end
endmodule

// ===== sv/cc20_core.sv =====
// Keystream block generator: state array, round sequencer around one
// quarter-round unit, final add. Depends on cc20_pkg and cc20_quarter.
module cc20_core #(
  parameter int DoubleRounds = cc20_pkg::DoubleRoundsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [511:0]   init_state,
  output logic           done,
  output logic [511:0]   keystream
);
  localparam int RndW = $clog2(DoubleRounds + 1);

  logic [31:0] work [16];
  logic [31:0] init [16];
  logic        busy;
  logic [2:0]  qstep;
  logic [RndW-1:0] rnd;
  logic        finish;
  logic [15:0] idx;
  cc20_pkg::quad_t qin, qout;

  assign idx = cc20_pkg::qr_index(qstep);
  assign qin = '{a: work[idx[15:12]], b: work[idx[11:8]],
                 c: work[idx[7:4]], d: work[idx[3:0]]};

  cc20_quarter u_qr (.in_q(qin), .out_q(qout));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      finish <= 1'b0;
      done <= 1'b0;
      qstep <= '0;
      rnd <= '0;
    end else begin
      done <= 1'b0;
      finish <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        qstep <= '0;
        rnd <= '0;
      end else if (busy) begin
        qstep <= qstep + 3'd1;
        if (qstep == 3'd7) begin
          if (rnd == RndW'(DoubleRounds - 1)) begin
            busy <= 1'b0;
            finish <= 1'b1;
          end
          rnd <= rnd + RndW'(1);
        end
      end
      if (finish) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) begin
        work[i] <= init_state[32*i +: 32];
        init[i] <= init_state[32*i +: 32];
      end
    end else if (busy) begin
      work[idx[15:12]] <= qout.a;
      work[idx[11:8]]  <= qout.b;
      work[idx[7:4]]   <= qout.c;
      work[idx[3:0]]   <= qout.d;
    end
    if (finish) begin
      for (int i = 0; i < 16; i++) keystream[32*i +: 32] <= work[i] + init[i];
    end
  end
endmodule

// ===== sv/chacha20_stream_xor.sv =====
// ChaCha20 stream XOR, 8 bytes per transfer. Depends on cc20_pkg,
// cc20_stream_if and cc20_core.
// A transfer that starts a keystream block (word position zero, a first
// word, or the word after a last word) has the core compute a new block,
// one quarter-round per cycle on the single shared quarter-round unit,
// before its result is formed; the other transfers of the block, up to
// seven, use the stored keystream. One item is in work at a time; the result
// sits in an output register until taken, and an item that finishes while the
// previous result still waits stalls by the cycles that result waits.
module chacha20_stream_xor #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DoubleRoundsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [cc20_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [cc20_pkg::CfgDataW-1:0] cfg_data,
  cc20_stream_if.sink   in_s,
  cc20_stream_if.source out_s
);
  logic [63:0] key [4];
  logic [31:0] salt, init_count;
  logic [31:0] block_count, nonce0, nonce1, nonce2;
  logic [2:0]  word_position;
  logic [63:0] message_count;
  logic [63:0] data_r;
  logic [3:0]  vb_r;
  logic        last_r;
  logic        start;
  logic        done;
  logic [511:0] ks, init_state;
  cc20_pkg::state_t state, state_next;
  logic [63:0] ksw, mask;
  logic [31:0] bc_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= '0; key[1] <= '0; key[2] <= '0; key[3] <= '0;
      salt <= '0;
      init_count <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        cc20_pkg::RegKey0: key[0] <= cfg_data;
        cc20_pkg::RegKey1: key[1] <= cfg_data;
        cc20_pkg::RegKey2: key[2] <= cfg_data;
        cc20_pkg::RegKey3: key[3] <= cfg_data;
        cc20_pkg::RegSalt: salt <= cfg_data[31:0];
        cc20_pkg::RegInitCount: init_count <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign in_s.ready = (state == cc20_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    start = 1'b0;
    case (state)
      cc20_pkg::ST_IDLE: if (in_s.valid) state_next = cc20_pkg::ST_LOAD;
      cc20_pkg::ST_LOAD: begin
        if (word_position == 3'd0) begin
          start = 1'b1;
          state_next = cc20_pkg::ST_ROUND;
        end else begin
          state_next = cc20_pkg::ST_FINAL;
        end
      end
      cc20_pkg::ST_ROUND: if (done) state_next = cc20_pkg::ST_FINAL;
      cc20_pkg::ST_FINAL: if (!out_s.valid || out_s.ready) state_next = cc20_pkg::ST_OUT;
      cc20_pkg::ST_OUT: state_next = cc20_pkg::ST_IDLE;
      default: state_next = cc20_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cc20_pkg::ST_IDLE;
    else state <= state_next;
  end

  assign init_state = {nonce2, nonce1, nonce0, block_count,
                       key[3], key[2], key[1], key[0],
                       cc20_pkg::Sigma3, cc20_pkg::Sigma2,
                       cc20_pkg::Sigma1, cc20_pkg::Sigma0};
  assign bc_eff = block_count;

  cc20_core #(.DoubleRounds(DOUBLE_ROUNDS)) u_core (
    .clk(clk), .rst(rst), .start(start), .init_state(init_state),
    .done(done), .keystream(ks)
  );

  assign ksw = ks[64*word_position +: 64];

  always_comb begin
    mask = '1;
    if (vb_r < 4'd8) begin
      for (int i = 0; i < 8; i++) mask[8*i +: 8] = (4'(i) < vb_r) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      word_position <= '0;
      nonce0 <= '0; nonce1 <= '0; nonce2 <= '0;
      message_count <= '0;
      out_s.valid <= 1'b0;
    end else begin
      if (in_s.valid && in_s.ready) begin
        data_r <= in_s.payload.data_word;
        vb_r <= in_s.payload.valid_bytes;
        last_r <= in_s.payload.last_word;
        if (in_s.payload.first_word) begin
          if (in_s.payload.own_nonce) begin
            nonce0 <= salt;
            nonce1 <= message_count[31:0];
            nonce2 <= message_count[63:32];
            message_count <= message_count + 64'd1;
          end else begin
            nonce0 <= in_s.payload.nonce_low[31:0];
            nonce1 <= in_s.payload.nonce_low[63:32];
            nonce2 <= in_s.payload.nonce_high;
          end
          block_count <= init_count;
          word_position <= '0;
        end
      end
      if (start) block_count <= bc_eff + 32'd1;
      if (state == cc20_pkg::ST_FINAL && (!out_s.valid || out_s.ready)) begin
        out_s.payload.out_word <= (data_r ^ ksw) & mask;
        out_s.payload.out_valid_bytes <= vb_r;
        out_s.payload.out_last <= last_r;
        out_s.payload.used_nonce_low <= {nonce1, nonce0};
        out_s.payload.used_nonce_high <= nonce2;
        word_position <= last_r ? 3'd0 : word_position + 3'd1;
      end
      if (state == cc20_pkg::ST_OUT) out_s.valid <= 1'b1;
      else if (out_s.valid && out_s.ready) out_s.valid <= 1'b0;
    end
  end
endmodule

// ===== sv/chacha20_stream_xor_chk.sv =====
// Port-level checker for chacha20_stream_xor, bound to the top level.
// Depends on cc20_stream_if.
module chacha20_stream_xor_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [3:0] out_vb,
  input logic [63:0] out_word
);
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after transfer");
  a_no_out_and_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid || !$past(out_valid && out_ready))
    else $error("spurious result");
  a_zero_mask: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_vb == 4'd0) |-> out_word == 64'd0) else $error("mask");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_word))
    else $error("result dropped");
endmodule

bind chacha20_stream_xor chacha20_stream_xor_chk u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_s.valid), .in_ready(in_s.ready),
  .out_valid(out_s.valid), .out_ready(out_s.ready),
  .out_vb(out_s.payload.out_valid_bytes), .out_word(out_s.payload.out_word)
);
